// ===== hdl/sogc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel-on-grid package
// Shared widths, constants and the 1-2-1 weighted sum helper.
// ----------------------------------------------------------------------------
package sogc_pkg;
	localparam int MaxLine   = 4096;
	localparam int AddrW     = $clog2(MaxLine);
	localparam int CoordW    = 5;
	localparam int CellW     = 3 * CoordW;
	localparam int LenW      = 13;
	localparam int CountW    = 12;
	localparam int GradW     = 11;
	localparam int SumW      = CoordW + 2;
	localparam int SqW       = 2 * SumW + 2;
	localparam int RadW      = SqW + 4;
	localparam int RootW     = RadW / 2;
	localparam logic [LenW-1:0] LenReset = LenW'(640);
	localparam logic [0:0] RegLineLength = 1'b0;
	// Byte address of the line length register on the configuration port.
	localparam logic [1:0] AddrLineLength = 2'(4 * RegLineLength);

	typedef logic [CellW-1:0] cell_t;

	// Weighted sum a + 2b + c of one coordinate component k.
	function automatic logic [SumW-1:0] wsum(cell_t a, cell_t b, cell_t c, int k);
		logic [SumW-1:0] r;
		r = SumW'(a[k*CoordW +: CoordW]) + {1'b0, b[k*CoordW +: CoordW], 1'b0}
			+ SumW'(c[k*CoordW +: CoordW]);
		return r;
	endfunction
endpackage

// ===== hdl/sogc_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line memory
// Synchronous one-read one-write memory holding two previous image rows.
// ----------------------------------------------------------------------------
module sogc_line_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [sogc_pkg::AddrW-1:0]  waddr,
	input  logic [2*sogc_pkg::CellW-1:0] wdata,
	input  logic                        re,
	input  logic [sogc_pkg::AddrW-1:0]  raddr,
	output logic [2*sogc_pkg::CellW-1:0] rdata
);
	logic [2*sogc_pkg::CellW-1:0] mem [sogc_pkg::MaxLine];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/sogc_grad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient unit
// Pipelined sums, squared norms and a bit-serial integer square root.
// ----------------------------------------------------------------------------
module sogc_grad (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sogc_pkg::cell_t               a, b, c, d, e, f,
	output logic                          done,
	output logic signed [sogc_pkg::GradW-1:0] grad
);
	localparam int StepW = $clog2(sogc_pkg::RootW + 1);
	logic [sogc_pkg::SumW-1:0] s1 [3];
	logic [sogc_pkg::SumW-1:0] s2 [3];
	logic [sogc_pkg::SqW-1:0]  n1_q, n2_q, dist_q;
	logic [sogc_pkg::RadW-1:0] rem_q;
	logic [sogc_pkg::RootW-1:0] root_q;
	logic [sogc_pkg::RadW-1:0] rad_q;
	logic [StepW-1:0] step_q;
	logic busy_q, sq_q;
	logic [sogc_pkg::RadW-1:0] trial;
	logic [sogc_pkg::RadW-1:0] rem_sh;

	function automatic logic [sogc_pkg::SqW-1:0] sqd(logic [sogc_pkg::SumW-1:0] p,
		logic [sogc_pkg::SumW-1:0] q);
		logic [sogc_pkg::SumW-1:0] m;
		m = (p > q) ? p - q : q - p;
		return sogc_pkg::SqW'(m) * sogc_pkg::SqW'(m);
	endfunction

	function automatic logic [sogc_pkg::SqW-1:0] sq(logic [sogc_pkg::SumW-1:0] p);
		return sogc_pkg::SqW'(p) * sogc_pkg::SqW'(p);
	endfunction

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s1[k] = sogc_pkg::wsum(a, b, c, k);
			s2[k] = sogc_pkg::wsum(d, e, f, k);
		end
	end

	logic [sogc_pkg::SumW-1:0] s1_s1 [3];
	logic [sogc_pkg::SumW-1:0] s2_s1 [3];
	always_ff @(posedge clk) begin
		if (start) begin
			s1_s1 <= s1;
			s2_s1 <= s2;
		end
	end

	// One magnitude/norm pass; a small multiply per component.
	always_ff @(posedge clk) begin
		if (sq_q) begin
			n1_q   <= sq(s1_s1[0]) + sq(s1_s1[1]) + sq(s1_s1[2]);
			n2_q   <= sq(s2_s1[0]) + sq(s2_s1[1]) + sq(s2_s1[2]);
			dist_q <= sqd(s1_s1[0], s2_s1[0]) + sqd(s1_s1[1], s2_s1[1])
				+ sqd(s1_s1[2], s2_s1[2]);
		end
	end

	// Restoring square root, two radicand bits per cycle.
	assign rem_sh = {rem_q[sogc_pkg::RadW-3:0], rad_q[sogc_pkg::RadW-1 -: 2]};
	assign trial  = sogc_pkg::RadW'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q   <= 1'b0;
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			sq_q <= start;
			done <= !sq_q && busy_q && step_q == StepW'(sogc_pkg::RootW);
			if (sq_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(sogc_pkg::RootW)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && step_q == '0) begin
			rad_q  <= {dist_q, 4'b0000};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[sogc_pkg::RadW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[sogc_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[sogc_pkg::RootW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		grad = (n1_q < n2_q) ? -sogc_pkg::GradW'(root_q) : sogc_pkg::GradW'(root_q);
	end
endmodule

// ===== hdl/sobel_on_grid_coordinates_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient over grid coordinates
// Two line rows in one synchronous memory, a 3x3 window, two gradient units.
// ----------------------------------------------------------------------------
// A result becomes valid after its input transfer passes the line memory read, then
// the window update and write back, then the norms and a ten-step bit-serial
// square root in the gradient units.
// An interior pixel holds off the next input until its result is taken; border
// pixels hold it off only while their line memory read is in flight.
// Reset clears counters, window and control; the line memory is unset until written.
module sobel_on_grid_coordinates_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  grid_x,
	input  logic [4:0]  grid_y,
	input  logic [4:0]  grid_z,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [10:0] row_gradient,
	output logic signed [10:0] column_gradient,
	output logic [11:0] centre_column,
	output logic [11:0] centre_row
);
	logic [sogc_pkg::LenW-1:0] len_q;
	logic [sogc_pkg::CountW-1:0] col_q, row_q, ccol_q, crow_q;
	sogc_pkg::cell_t win_q [3][3];
	sogc_pkg::cell_t px_q;
	logic [sogc_pkg::AddrW-1:0] addr_q;
	logic rd_q, busy_q, fire_q;
	logic [2*sogc_pkg::CellW-1:0] rdata;
	logic [sogc_pkg::CountW-1:0] col_in, row_in;
	logic [sogc_pkg::LenW-1:0] eff;
	logic done_r, done_c;
	logic signed [10:0] gr, gc;
	logic accept;

	assign pready = 1'b1;
	assign prdata = (paddr == sogc_pkg::AddrLineLength) ? 32'(len_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= sogc_pkg::LenReset;
		end else if (psel && penable && pwrite && paddr == sogc_pkg::AddrLineLength) begin
			len_q <= pwdata[sogc_pkg::LenW-1:0];
		end
	end

	function automatic logic [4:0] clampc(logic [4:0] v);
		return v;
	endfunction

	assign eff = (len_q < 13'd3) ? 13'd3 : (len_q > 13'd4096) ? 13'd4096 : len_q;
	assign col_in = frame_start ? '0 : col_q;
	assign row_in = frame_start ? '0 : row_q;

	// For an interior pixel, busy holds from acceptance through gradient and output transfer.
	assign in_ready = !busy_q && !rd_q;
	assign accept   = in_valid && in_ready;

	sogc_line_mem u_mem (
		.clk(clk), .we(rd_q), .waddr(addr_q),
		.wdata({rdata[sogc_pkg::CellW-1:0], px_q}),
		.re(accept), .raddr(col_in), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0; rd_q <= 1'b0; busy_q <= 1'b0; fire_q <= 1'b0;
			out_valid <= 1'b0;
			px_q <= '0; addr_q <= '0; ccol_q <= '0; crow_q <= '0;
			for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
		end else begin
			fire_q <= rd_q && busy_q;
			rd_q   <= accept;
			if (accept) begin
				px_q   <= {clampc(grid_z), clampc(grid_y), clampc(grid_x)};
				addr_q <= col_in;
				ccol_q <= col_in - 1'b1;
				crow_q <= row_in - 1'b1;
				busy_q <= col_in >= 12'd2 && row_in >= 12'd2;
				if (13'(col_in) + 13'd1 >= eff) begin
					col_q <= '0;
					row_q <= (row_in < 12'd4095) ? row_in + 1'b1 : row_in;
				end else begin
					col_q <= col_in + 1'b1;
					row_q <= row_in;
				end
			end else if (out_valid && out_ready) begin
				busy_q <= 1'b0;
			end
			if (rd_q) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= rdata[2*sogc_pkg::CellW-1:sogc_pkg::CellW];
				win_q[1][2] <= rdata[sogc_pkg::CellW-1:0];
				win_q[2][2] <= px_q;
			end
			if (done_r) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	sogc_grad u_row (
		.clk(clk), .arst_n(arst_n), .start(fire_q),
		.a(win_q[0][0]), .b(win_q[0][1]), .c(win_q[0][2]),
		.d(win_q[2][0]), .e(win_q[2][1]), .f(win_q[2][2]),
		.done(done_r), .grad(gr)
	);
	sogc_grad u_col (
		.clk(clk), .arst_n(arst_n), .start(fire_q),
		.a(win_q[0][0]), .b(win_q[1][0]), .c(win_q[2][0]),
		.d(win_q[0][2]), .e(win_q[1][2]), .f(win_q[2][2]),
		.done(done_c), .grad(gc)
	);

	assign row_gradient    = gr;
	assign column_gradient = gc;
	assign centre_column   = ccol_q;
	assign centre_row      = crow_q;

	a_units_agree: assert property (@(posedge clk) disable iff (!arst_n) done_r == done_c)
		else $error("gradient units out of step");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_fire_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		fire_q |-> $past(rd_q)) else $error("window fired without a read");
endmodule
